### rtl/core/qpht_pkg.sv
// Package with field widths, default table size and result codes of the quadratic probe hash table.
package qpht_pkg;

  localparam int unsigned QPHT_SLOTS = 16;

  localparam int unsigned KEY_W    = 31;
  localparam int unsigned IDX_W    = 4;
  localparam int unsigned ST_W     = 2;
  localparam int unsigned S_DATA_W = 32;
  localparam int unsigned M_DATA_W = 8;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  localparam logic [ST_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

endpackage

### rtl/core/qpht_modadd.sv
// Shared modular adder: (a + b + carry in) reduced once by the table size.
module qpht_modadd #(
  parameter int unsigned MODULUS = 16,
  parameter int unsigned W       = 4
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic         cin_i,
  output logic [W-1:0] res_o
);

  localparam logic [W:0] ModVal = (W+1)'(MODULUS);

  logic [W:0] sum;
  logic [W:0] diff;

  // Both operands stay below the modulus, so one conditional subtract suffices.
  assign sum   = {1'b0, a_i} + {1'b0, b_i} + {{W{1'b0}}, cin_i};
  assign diff  = sum - ModVal;
  assign res_o = (sum >= ModVal) ? diff[W-1:0] : sum[W-1:0];

endmodule

### rtl/core/quadratic_probe_hash_table_top.sv
// Top level of the quadratic probe hash table: sequencer, slot memory and output register.
//
//   Channel   Direction  Transaction content
//   s_axis    in         tuser: operation, tdata: key
//   m_axis    out        tuser: status,    tdata: slot_index
//
// A transaction visits k probes, where k is from 1 to TABLE_SLOTS: states S_MOD and S_HOME
// find the home slot by multiplying the key with a constant reciprocal of the table size,
// and each probe reads the slot memory in S_READ and checks it in S_CHECK, with the next
// slot formed by a single shared modular adder. After reset a clearing pass writes every
// slot empty before the first transaction is taken. A result waits in the output register
// while the next transaction is already being accepted and worked on; S_DONE holds a new
// result until that register is free.
module quadratic_probe_hash_table_top #(
  parameter int unsigned TABLE_SLOTS = qpht_pkg::QPHT_SLOTS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [qpht_pkg::S_DATA_W-1:0]  s_axis_tdata_i,   // [30:0] key, [31] ignored
  input  logic                           s_axis_tuser_i,   // [0] operation
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [qpht_pkg::M_DATA_W-1:0]  m_axis_tdata_o,   // [3:0] slot_index, [7:4] zero
  output logic [qpht_pkg::ST_W-1:0]      m_axis_tuser_o    // [1:0] status
);

  import qpht_pkg::*;

  localparam int unsigned IW  = $clog2(TABLE_SLOTS);
  localparam int unsigned MW  = KEY_W + 1;
  localparam int unsigned RW  = KEY_W + 1;
  localparam int unsigned PW  = KEY_W + RW;
  localparam int unsigned RecipShift = KEY_W + IW;
  localparam logic [IW-1:0] LastSlot = IW'(TABLE_SLOTS - 1);

  // Rounded-up reciprocal that makes the shifted product the exact quotient for any key.
  localparam logic [63:0] RecipWide =
    ((64'd1 << RecipShift) + 64'(TABLE_SLOTS) - 64'd1) / 64'(TABLE_SLOTS);
  localparam logic [RW-1:0]    Recip    = RecipWide[RW-1:0];
  localparam logic [KEY_W-1:0] SlotsKey = KEY_W'(TABLE_SLOTS);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HOME,
    S_READ,
    S_CHECK,
    S_DONE
  } state_e;

  state_e              state_q;
  logic [KEY_W-1:0]    key_q;
  logic                op_q;
  logic [KEY_W-1:0]    quot_q;
  logic [IW-1:0]       p_q;
  logic [IW-1:0]       d_q;
  logic [IW-1:0]       cnt_q;
  logic [ST_W-1:0]     res_st_q;
  logic [IDX_W-1:0]    res_idx_q;
  logic                m_valid_q;
  logic [ST_W-1:0]     m_st_q;
  logic [IDX_W-1:0]    m_idx_q;

  logic [MW-1:0]       mem_q [TABLE_SLOTS];
  logic [MW-1:0]       rdata_q;

  logic [IW-1:0]       unit_a;
  logic [IW-1:0]       unit_b;
  logic                unit_cin;
  logic [IW-1:0]       unit_res;

  logic                wr_en;
  logic [IW-1:0]       wr_addr;
  logic [MW-1:0]       wr_data;

  logic [PW-1:0]       quot_prod;
  logic [IW-1:0]       home;
  logic                slot_used;
  logic [KEY_W-1:0]    slot_key;
  logic                last_probe;
  logic [IW+IDX_W-1:0] p_ext;
  logic                s_fire;
  logic                out_free;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;

  assign slot_used  = rdata_q[MW-1];
  assign slot_key   = rdata_q[KEY_W-1:0];
  assign last_probe = (cnt_q == LastSlot);
  assign p_ext      = {{IDX_W{1'b0}}, p_q};

  // The remainder is below the table size, so its low bits alone give the home slot.
  assign quot_prod = {{RW{1'b0}}, key_q} * {{KEY_W{1'b0}}, Recip};
  assign home      = key_q[IW-1:0] - IW'(quot_q * SlotsKey);

  // Operand selection for the one modular adder.
  always_comb begin
    case (state_q)
      S_READ: begin
        unit_a   = d_q;
        unit_b   = IW'(1);
        unit_cin = 1'b1;
      end
      default: begin
        unit_a   = p_q;
        unit_b   = d_q;
        unit_cin = 1'b0;
      end
    endcase
  end

  qpht_modadd #(
    .MODULUS (TABLE_SLOTS),
    .W       (IW)
  ) u_modadd (
    .a_i   (unit_a),
    .b_i   (unit_b),
    .cin_i (unit_cin),
    .res_o (unit_res)
  );

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = p_q;
    wr_data = {1'b1, key_q};
    if (state_q == S_CLEAR) begin
      wr_en   = 1'b1;
      wr_addr = cnt_q;
      wr_data = '0;
    end else if (state_q == S_CHECK && op_q == OP_INSERT && !slot_used) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    rdata_q <= mem_q[p_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      cnt_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          cnt_q <= cnt_q + IW'(1);
          if (last_probe) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (s_fire) begin
            key_q   <= s_axis_tdata_i[KEY_W-1:0];
            op_q    <= s_axis_tuser_i;
            // Starting the step at minus one makes the first increment give one.
            d_q     <= LastSlot;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          quot_q  <= KEY_W'(quot_prod >> RecipShift);
          state_q <= S_HOME;
        end
        S_HOME: begin
          p_q     <= home;
          cnt_q   <= '0;
          state_q <= S_READ;
        end
        S_READ: begin
          d_q     <= unit_res;
          state_q <= S_CHECK;
        end
        S_CHECK: begin
          if (op_q == OP_INSERT) begin
            if (!slot_used) begin
              res_st_q  <= ST_INSERTED;
              res_idx_q <= p_ext[IDX_W-1:0];
              state_q   <= S_DONE;
            end else if (last_probe) begin
              res_st_q  <= ST_FULL;
              res_idx_q <= '0;
              state_q   <= S_DONE;
            end else begin
              p_q     <= unit_res;
              cnt_q   <= cnt_q + IW'(1);
              state_q <= S_READ;
            end
          end else begin
            if (slot_used && slot_key == key_q) begin
              res_st_q  <= ST_FOUND;
              res_idx_q <= p_ext[IDX_W-1:0];
              state_q   <= S_DONE;
            end else if (!slot_used || last_probe) begin
              res_st_q  <= ST_NOT_FOUND;
              res_idx_q <= '0;
              state_q   <= S_DONE;
            end else begin
              p_q     <= unit_res;
              cnt_q   <= cnt_q + IW'(1);
              state_q <= S_READ;
            end
          end
        end
        S_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_st_q    <= res_st_q;
            m_idx_q   <= res_idx_q;
            state_q   <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_st_q;
  assign m_axis_tdata_o  = {{(M_DATA_W - IDX_W){1'b0}}, m_idx_q};

endmodule

### test/quadratic_probe_hash_table_top_test.sv
// Self-checking testbench for the quadratic probe hash table: inserts and searches against a mirrored table.
module quadratic_probe_hash_table_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  import qpht_pkg::*;

  localparam int unsigned SLOTS        = QPHT_SLOTS;
  localparam int unsigned RANDOM_OPS   = 800;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 80;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CALM_FROM    = 400;
  localparam int unsigned CALM_TO      = 560;
  localparam int unsigned IDLE_PERCENT = 18;

  typedef struct packed {
    logic             op;
    logic             stray;
    logic [KEY_W-1:0] key;
  } table_op_t;

  typedef struct packed {
    logic [ST_W-1:0]  status;
    logic [IDX_W-1:0] slot_index;
  } table_reply_t;

  logic                clk_i;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [S_DATA_W-1:0] s_axis_tdata = '0;
  logic                s_axis_tuser = OP_INSERT;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [M_DATA_W-1:0] m_axis_tdata;
  logic [ST_W-1:0]     m_axis_tuser;

  // Mirror of the table contents and the ordered results still owed by the block.
  logic [KEY_W-1:0] slot_key_mirror [SLOTS];
  logic             slot_used_mirror [SLOTS];
  table_op_t        pending_ops[$];
  table_reply_t     awaited_results[$];

  table_op_t   drive_op;
  table_reply_t head_result;
  logic        s_taken = 1'b0;
  logic        m_taken = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned ops_accepted = 0;
  int unsigned quiet_cycles = 0;
  int unsigned mismatch_count = 0;
  logic        calm;

  assign calm = (ops_accepted >= CALM_FROM) && (ops_accepted < CALM_TO);

  quadratic_probe_hash_table_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    foreach (slot_used_mirror[i]) begin
      slot_used_mirror[i] = 1'b0;
      slot_key_mirror[i]  = '0;
    end
  end

  // Applies one operation to the mirrored table and returns the result it must produce.
  function automatic table_reply_t apply_op(table_op_t t);
    int unsigned  home;
    int unsigned  s;
    table_reply_t r;
    home = t.key % SLOTS;
    r.slot_index = '0;
    if (t.op == OP_INSERT) begin
      r.status = ST_FULL;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        s = (home + i * i) % SLOTS;
        if (!slot_used_mirror[s]) begin
          slot_used_mirror[s] = 1'b1;
          slot_key_mirror[s]  = t.key;
          r.status     = ST_INSERTED;
          r.slot_index = s[IDX_W-1:0];
          break;
        end
      end
    end else begin
      r.status = ST_NOT_FOUND;
      for (int unsigned i = 0; i < SLOTS; i++) begin
        s = (home + i * i) % SLOTS;
        if (!slot_used_mirror[s]) break;
        if (slot_key_mirror[s] == t.key) begin
          r.status     = ST_FOUND;
          r.slot_index = s[IDX_W-1:0];
          break;
        end
      end
    end
    return r;
  endfunction

  function automatic table_op_t make_op(logic op, logic [KEY_W-1:0] key, logic stray);
    table_op_t t;
    t.op    = op;
    t.key   = key;
    t.stray = stray;
    return t;
  endfunction

  // Sender: a new transaction is offered only once the previous one has been taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || s_taken)) begin
      if (pending_ops.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
        drive_op = pending_ops.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {drive_op.stray, drive_op.key};
        s_axis_tuser  <= drive_op.op;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random back-pressure plus one long hold-off that fills the block.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left != 0) begin
        m_axis_tready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (!hold_done && ops_accepted >= HOLD_AT) begin
        hold_done     <= 1'b1;
        hold_left     <= HOLD_CYCLES;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
    end
  end

  // Checker and watchdog, both sampled at the rising edge.
  always @(posedge clk_i) begin
    s_taken = rst_ni && s_axis_tvalid && s_axis_tready;
    m_taken = rst_ni && m_axis_tvalid && m_axis_tready;
    if (m_taken) begin
      if (awaited_results.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                 $time, m_axis_tuser, m_axis_tdata);
      end else begin
        head_result = awaited_results.pop_front();
        if (m_axis_tuser !== head_result.status) begin
          mismatch_count++;
          $display("%0t: status mismatch, expected %0d, actual %0d",
                   $time, head_result.status, m_axis_tuser);
        end
        if (m_axis_tdata !== {{(M_DATA_W-IDX_W){1'b0}}, head_result.slot_index}) begin
          mismatch_count++;
          $display("%0t: slot_index mismatch, expected %0d, actual %0d (tdata %h)",
                   $time, head_result.slot_index, m_axis_tdata[IDX_W-1:0], m_axis_tdata);
        end
      end
    end
    if (s_taken) begin
      awaited_results.push_back(apply_op(drive_op));
      ops_accepted++;
    end
    if (s_taken || m_taken) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    logic [KEY_W-1:0] stored_keys[$];
    logic [KEY_W-1:0] k;
    logic             op;
    int unsigned      roll;

    // Home slot 0 reaches only slots 0, 1, 4 and 9, so four inserts exhaust its probe chain.
    pending_ops.push_back(make_op(OP_SEARCH, 31'd5, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'd0, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'd16, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'd32, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'd0, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'd48, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd48, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd0, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd32, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd17, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'h7FFF_FFFF, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'h7FFF_FFFF, 1'b0));
    pending_ops.push_back(make_op(OP_INSERT, 31'h7FFF_FFF0, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd16, 1'b1));
    pending_ops.push_back(make_op(OP_INSERT, 31'd3, 1'b1));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd3, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'h7FFF_FFEF, 1'b0));
    pending_ops.push_back(make_op(OP_SEARCH, 31'd1, 1'b1));
    stored_keys = '{31'd0, 31'd16, 31'd32, 31'h7FFF_FFFF, 31'd3};

    // Mostly searches, half of them for keys that were inserted earlier.
    for (int unsigned n = 0; n < RANDOM_OPS; n++) begin
      roll = $urandom_range(0, 99);
      op = (roll < 30) ? OP_INSERT : OP_SEARCH;
      if (op == OP_SEARCH && stored_keys.size() != 0 && $urandom_range(0, 1) == 1) begin
        k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
      end else if ($urandom_range(0, 1) == 1) begin
        k = KEY_W'($urandom);
      end else begin
        k = KEY_W'($urandom_range(0, 255));
      end
      if (op == OP_INSERT) stored_keys.push_back(k);
      pending_ops.push_back(make_op(op, k, $urandom_range(0, 9) == 0));
    end

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (pending_ops.size() != 0 || s_axis_tvalid || awaited_results.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0 && awaited_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/qpht_pkg.sv
rtl/core/qpht_modadd.sv
rtl/core/quadratic_probe_hash_table_top.sv
test/quadratic_probe_hash_table_top_test.sv
